FILE: rtl/envsc_pkg.sv
// shared constants, types and helper functions of the sensor compensation core
`default_nettype none
package envsc_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned IDX_W  = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TEMP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESS_A = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRESS_B = 3'd2;
	localparam logic [IDX_W-1:0] REG_P9      = 3'd3;
	localparam logic [IDX_W-1:0] REG_HUM     = 3'd4;
	localparam logic [IDX_W-1:0] REG_H6      = 3'd5;

	localparam logic [23:0] DISABLED_24 = 24'h800000;
	localparam logic [15:0] DISABLED_16 = 16'h8000;
	localparam logic [31:0] HUM_MAX     = 32'd419430400;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} op_req_t;

	function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
		return {{(WORD_W-16){v[15]}}, v};
	endfunction

	function automatic logic [WORD_W-1:0] sx8(input logic [7:0] v);
		return {{(WORD_W-8){v[7]}}, v};
	endfunction

	function automatic logic [WORD_W-1:0] sx32(input logic [WORD_W-1:0] v);
		return {{(WORD_W-32){v[31]}}, v[31:0]};
	endfunction

	// 32-bit arithmetic shift of the low word, sign extended back to 64 bits
	function automatic logic [WORD_W-1:0] asr32(input logic [WORD_W-1:0] v,
			input logic [4:0] s);
		logic signed [31:0] r;
		r = $signed(v[31:0]) >>> s;
		return {{(WORD_W-32){r[31]}}, r};
	endfunction

	function automatic logic [WORD_W-1:0] asr64(input logic [WORD_W-1:0] v,
			input logic [5:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/envsc_mul.sv
// shift-add multiplier, one multiplier bit per cycle, low 64 product bits
`default_nettype none
module envsc_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire envsc_pkg::op_req_t       req,
	output logic                          busy,
	output logic [envsc_pkg::WORD_W-1:0]  prod
);
	import envsc_pkg::*;

	logic [WORD_W-1:0]         acc_q, mcand_q, mplier_q;
	logic [$clog2(WORD_W)-1:0] cnt_q;
	logic                      busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == WORD_W[$clog2(WORD_W)-1:0] - 1'b1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= req.a;
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[WORD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WORD_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

FILE: rtl/envsc_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module envsc_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire envsc_pkg::op_req_t       req,
	output logic                          busy,
	output logic [envsc_pkg::WORD_W-1:0]  quot
);
	import envsc_pkg::*;

	logic [WORD_W:0]           rem_q;
	logic [WORD_W-1:0]         quo_q, den_q;
	logic                      neg_q, busy_q;
	logic [$clog2(WORD_W)-1:0] cnt_q;
	logic [WORD_W:0]           rem_sh, trial;

	assign rem_sh = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == WORD_W[$clog2(WORD_W)-1:0] - 1'b1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.a[WORD_W-1] ? -req.a : req.a;
			den_q <= req.b[WORD_W-1] ? -req.b : req.b;
			neg_q <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? -quo_q : quo_q;
endmodule
`default_nettype wire

FILE: rtl/env_sensor_compensation_core.sv
// Sensor compensation core: one shared multiplier, one divider, step sequencer.
// Sequence: each multiply and the divide are issued by their step and waited for; with all three
// readings enabled an item takes 21 multiplies, one divide and three steps that issue neither,
// and m_tvalid rises when the item finishes; a held result delays the finish.
// One item at a time: s_tready is high only while idle, so no new item is taken before the last
// is computed. Reset clears configuration registers, fine temperature and the handshake state.
`default_nettype none
module env_sensor_compensation_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raw_pressure[23:0], raw_temperature[47:24], raw_humidity[63:48]
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// temperature[31:0], temperature_valid[32], pressure[64:33], pressure_valid[65],
	// humidity[72:66], humidity_valid[73], zero[79:74]
	output logic [79:0]      m_tdata
);
	import envsc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_WMUL = 5'b00100,
		ST_WDIV = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [4:0] T_A = 5'd0, T_B = 5'd1, T_C = 5'd2, T_D = 5'd3;
	localparam logic [4:0] P_0 = 5'd4, P_1 = 5'd5, P_2 = 5'd6, P_3 = 5'd7;
	localparam logic [4:0] P_4 = 5'd8, P_5 = 5'd9, P_6 = 5'd10, P_7 = 5'd11;
	localparam logic [4:0] P_8 = 5'd12, P_9 = 5'd13, P_10 = 5'd14, P_11 = 5'd15;
	localparam logic [4:0] H_0 = 5'd16, H_1 = 5'd17, H_2 = 5'd18, H_3 = 5'd19;
	localparam logic [4:0] H_4 = 5'd20, H_5 = 5'd21, H_6 = 5'd22, H_7 = 5'd23;
	localparam logic [4:0] H_8 = 5'd24;

	state_t state_q;
	logic [4:0] pc_q;

	logic [47:0] t_q;
	logic [63:0] pa_q, pb_q, h_q;
	logic [15:0] p9_q;
	logic [7:0]  h6_q;
	logic [31:0] fine_q;

	logic [23:0] rp_q, rt_q;
	logic [15:0] rh_q;
	logic        tv_q, pv_q, hv_q;
	logic [31:0] temp_q, press_q;
	logic [6:0]  hum_q;
	logic [63:0] ra_q, rb_q, rc_q, rd_q, re_q;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;

	op_req_t     mul_req, div_req;
	logic        mul_busy, div_busy;
	logic [63:0] prod, quot;

	envsc_mul u_mul (.clk, .arst_n, .req(mul_req), .busy(mul_busy), .prod);
	envsc_div u_div (.clk, .arst_n, .req(div_req), .busy(div_busy), .quot);

	// calibration words
	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] h1, h2, h3, h4, h5, h6;
	assign t1 = {48'd0, t_q[15:0]};
	assign t2 = sx16(t_q[31:16]);
	assign t3 = sx16(t_q[47:32]);
	assign p1 = {48'd0, pa_q[15:0]};
	assign p2 = sx16(pa_q[31:16]);
	assign p3 = sx16(pa_q[47:32]);
	assign p4 = sx16(pa_q[63:48]);
	assign p5 = sx16(pb_q[15:0]);
	assign p6 = sx16(pb_q[31:16]);
	assign p7 = sx16(pb_q[47:32]);
	assign p8 = sx16(pb_q[63:48]);
	assign p9 = sx16(p9_q);
	assign h1 = {56'd0, h_q[7:0]};
	assign h2 = sx16(h_q[23:8]);
	assign h3 = {56'd0, h_q[31:24]};
	assign h4 = sx16(h_q[47:32]);
	assign h5 = sx16(h_q[63:48]);
	assign h6 = sx8(h6_q);

	logic [19:0] adc_t, adc_p;
	assign adc_t = rt_q[23:4];
	assign adc_p = rp_q[23:4];

	// step datapath terms
	logic [31:0] t_x, t_d, t_f, t_f5;
	logic [63:0] t_v2, p_a, p_e, p_base, p_n, p_q1, p_sum, p_fin;
	logic [31:0] h_v, h_x, h_out;
	logic [63:0] h_s;
	assign t_x   = {15'd0, adc_t[19:3]} - {15'd0, t1[15:0], 1'b0};
	assign t_d   = {16'd0, adc_t[19:4]} - t1[31:0];
	assign t_v2  = asr32(prod, 5'd14);
	assign t_f   = rb_q[31:0] + t_v2[31:0];
	assign t_f5  = {t_f[29:0], 2'b00} + t_f + 32'd128;
	assign p_a   = sx32({32'd0, fine_q}) - 64'd128000;
	assign p_e   = asr64(prod, 6'd33);
	assign p_base = 64'd1048576 - {44'd0, adc_p};
	assign p_n   = {p_base[32:0], 31'd0};
	assign p_q1  = asr64(quot, 6'd13);
	assign p_sum = asr64(ra_q + rc_q + asr64(prod, 6'd19), 6'd8) + {p7[59:0], 4'd0};
	assign p_fin = asr64(p_sum, 6'd8);
	assign h_v   = fine_q - 32'd76800;
	assign h_x   = {2'd0, rh_q, 14'd0} - {h4[11:0], 20'd0} - prod[31:0] + 32'd16384;
	assign h_s   = asr32(prod, 5'd4);
	assign h_out = ra_q[31:0] - h_s[31:0];

	logic [63:0] h_tmp_a, h_tmp_b;
	assign h_tmp_a = asr32(prod, 5'd11) + 64'd32768;
	assign h_tmp_b = asr32(prod + 64'd8192, 5'd14);

	always_comb begin
		mul_req = '0;
		div_req = '0;
		if (state_q == ST_RUN) begin
			case (pc_q)
				T_A: mul_req = '{tv_q, sx32({32'd0, t_x}), t2};
				T_B: mul_req = '{1'b1, sx32({32'd0, t_d}), sx32({32'd0, t_d})};
				T_C: mul_req = '{1'b1, asr32(prod, 5'd12), t3};
				P_0: mul_req = '{pv_q, p_a, p_a};
				P_1: mul_req = '{1'b1, prod, p6};
				P_2: mul_req = '{1'b1, ra_q, p5};
				P_3: mul_req = '{1'b1, rb_q, p3};
				P_4: mul_req = '{1'b1, ra_q, p2};
				P_5: mul_req = '{1'b1, 64'h0000_8000_0000_0000 + rd_q + {prod[51:0], 12'd0},
						p1};
				P_6: mul_req = '{(p_e != 64'd0), p_n - rc_q, 64'd3125};
				P_8: mul_req = '{1'b1, p9, p_q1};
				P_9: mul_req = '{1'b1, prod, rb_q};
				P_10: mul_req = '{1'b1, p8, ra_q};
				H_0: mul_req = '{hv_q, h5, sx32({32'd0, h_v})};
				H_1: mul_req = '{1'b1, ra_q, h6};
				H_2: mul_req = '{1'b1, ra_q, h3};
				H_3: mul_req = '{1'b1, rd_q, h_tmp_a};
				H_4: mul_req = '{1'b1, asr32(prod, 5'd10) + 64'd2097152, h2};
				H_5: mul_req = '{1'b1, rc_q, h_tmp_b};
				H_6: mul_req = '{1'b1, asr32(prod, 5'd15), asr32(prod, 5'd15)};
				H_7: mul_req = '{1'b1, asr32(prod, 5'd7), h1};
				P_7: div_req = '{1'b1, prod, re_q};
				default: ;
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q  <= '0;
			pa_q <= '0;
			pb_q <= '0;
			p9_q <= '0;
			h_q  <= '0;
			h6_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP:    t_q  <= cfg_data[47:0];
				REG_PRESS_A: pa_q <= cfg_data;
				REG_PRESS_B: pb_q <= cfg_data;
				REG_P9:      p9_q <= cfg_data[15:0];
				REG_HUM:     h_q  <= cfg_data;
				REG_H6:      h6_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= T_A;
			fine_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						pc_q    <= T_A;
					end
				end
				ST_RUN: begin
					pc_q <= pc_q + 1'b1;
					if (mul_req.start) state_q <= ST_WMUL;
					if (div_req.start) state_q <= ST_WDIV;
					case (pc_q)
						T_A: if (!tv_q) pc_q <= P_0;
						T_D: fine_q <= t_f;
						P_0: if (!pv_q) pc_q <= H_0;
						P_6: if (p_e == 64'd0) pc_q <= H_0;
						H_0: if (!hv_q) state_q <= ST_DONE;
						H_8: state_q <= ST_DONE;
						default: ;
					endcase
				end
				ST_WMUL: if (!mul_busy) state_q <= ST_RUN;
				ST_WDIV: if (!div_busy) state_q <= ST_RUN;
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			rp_q    <= s_tdata[23:0];
			rt_q    <= s_tdata[47:24];
			rh_q    <= s_tdata[63:48];
			pv_q    <= s_tdata[23:0] != DISABLED_24;
			tv_q    <= s_tdata[47:24] != DISABLED_24;
			hv_q    <= s_tdata[63:48] != DISABLED_16;
			temp_q  <= '0;
			press_q <= '0;
			hum_q   <= '0;
		end
		if (state_q == ST_RUN) begin
			case (pc_q)
				T_B: rb_q <= asr32(prod, 5'd11);
				T_D: temp_q <= $unsigned($signed(t_f5) >>> 8);
				P_0: ra_q <= p_a;
				P_1: rb_q <= prod;
				P_2: rc_q <= prod;
				P_3: rc_q <= rc_q + {prod[46:0], 17'd0} + {p4[28:0], 35'd0};
				P_4: rd_q <= asr64(prod, 6'd8);
				P_6: re_q <= p_e;
				P_8: begin
					ra_q <= quot;
					rb_q <= p_q1;
				end
				P_10: rc_q <= asr64(prod, 6'd25);
				P_11: press_q <= p_fin[31:0];
				H_0: ra_q <= sx32({32'd0, h_v});
				H_1: rc_q <= asr32({32'd0, h_x}, 5'd15);
				H_2: rd_q <= asr32(prod, 5'd10);
				H_6: ra_q <= sx32(prod);
				H_8: begin
					if (h_out[31]) hum_q <= '0;
					else if (h_out > HUM_MAX) hum_q <= HUM_MAX[28:22];
					else hum_q <= h_out[28:22];
				end
				default: ;
			endcase
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {6'd0, hv_q, hum_q, pv_q, press_q, tv_q, temp_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule
`default_nettype wire
